FILE: rtl/efsd_pkg.sv
// constants and widths shared by the earliest-free server dispatcher
// no dependencies
package efsd_pkg;

  localparam int unsigned NUM_SERVERS_DEF = 16;

  localparam int unsigned ACTIVE_W  = 5;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned ARRIVAL_W = 24;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned SERVER_W  = 4;
  localparam int unsigned WAIT_W    = 32;
  localparam int unsigned TOTAL_W   = 48;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned BUSY_W    = 32;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // register index, selected by paddr[2]
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd1;
  localparam logic [THRESH_W-1:0] THRESH_RST = 16'd10;

endpackage

FILE: rtl/efsd_if.sv
// request and result channel interfaces of the dispatcher
// depends on efsd_pkg
interface efsd_req_if;
  logic                              valid;
  logic                              ready;
  logic [efsd_pkg::ARRIVAL_W-1:0]    arrival_time;
  logic [efsd_pkg::DUR_W-1:0]        service_duration;

  modport source (output valid, arrival_time, service_duration, input ready);
  modport sink   (input valid, arrival_time, service_duration, output ready);
endinterface

interface efsd_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [efsd_pkg::SERVER_W-1:0]     assigned_server;
  logic [efsd_pkg::WAIT_W-1:0]       wait_time;
  logic [efsd_pkg::TOTAL_W-1:0]      total_wait;
  logic [efsd_pkg::COUNT_W-1:0]      long_wait_count;
  logic [efsd_pkg::COUNT_W-1:0]      requests_seen;

  modport source (output valid, assigned_server, wait_time, total_wait,
                  long_wait_count, requests_seen, input ready);
  modport sink   (input valid, assigned_server, wait_time, total_wait,
                  long_wait_count, requests_seen, output ready);
endinterface

FILE: rtl/earliest_free_server_dispatcher_unit.sv
// top level of the earliest-free server dispatcher: busy-until memory,
// scan sequencer, statistics counters and apb register port
// depends on efsd_pkg and efsd_if
//
//   channel  dir  handshake            payload
//   req_i    in   valid/ready          arrival_time, service_duration
//   rsp_o    out  valid/ready          assigned_server, wait_time, total_wait,
//                                      long_wait_count, requests_seen
//   apb      in   psel/penable/pready  active_servers @0x0, long_wait_threshold @0x4
//
// a request runs from one accept to the next through n reads over the single read port,
// n being active_servers clamped to 1..NUM_SERVERS, the registered read of the last entry,
// the write-back and a return to idle with ready high.
// the result is registered at the write-back.
// reset clears the counters and the per-server valid bits and sets the registers to their defaults at once.
// the write-back waits while a previous result is still held on rsp_o.
module earliest_free_server_dispatcher_unit #(
  parameter int unsigned NUM_SERVERS = efsd_pkg::NUM_SERVERS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  efsd_req_if.sink                          req_i,
  efsd_rsp_if.source                        rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [efsd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [efsd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [efsd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import efsd_pkg::*;

  localparam int unsigned IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SERVERS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  // config registers
  logic [ACTIVE_W-1:0] active_q;
  logic [THRESH_W-1:0] thresh_q;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RST;
      thresh_q <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ACTIVE: active_q <= pwdata[ACTIVE_W-1:0];
        REG_THRESH: thresh_q <= pwdata[THRESH_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE: prdata = {{(APB_DATA_W-ACTIVE_W){1'b0}}, active_q};
      REG_THRESH: prdata = {{(APB_DATA_W-THRESH_W){1'b0}}, thresh_q};
      default:    prdata = '0;
    endcase
  end

  // sequencer state
  logic [1:0]            state_q, state_d;
  logic [ARRIVAL_W-1:0]  arrival_q;
  logic [DUR_W-1:0]      dur_q;
  logic [IDX_W-1:0]      last_q;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  pend_vld_q;
  logic [IDX_W-1:0]      pend_idx_q;
  logic                  found_q;
  logic [IDX_W-1:0]      first_idx_q;
  logic [BUSY_W-1:0]     best_q;
  logic [IDX_W-1:0]      best_idx_q;

  // busy-until memory with per-entry valid bits
  logic [BUSY_W-1:0]     busy_mem [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] ent_vld_q;
  logic [BUSY_W-1:0]     rd_data_q;
  logic                  rd_vld_q;
  logic                  rd_en;
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_idx;
  logic [BUSY_W-1:0]     wr_data;

  // statistics and result register
  logic [TOTAL_W-1:0]    total_q;
  logic [COUNT_W-1:0]    long_q;
  logic [COUNT_W-1:0]    cnt_q;
  logic                  out_vld_q;
  logic [SERVER_W-1:0]   out_srv_q;
  logic [WAIT_W-1:0]     out_wait_q;

  logic                  req_acc;
  logic                  out_free;
  logic [CNT_W-1:0]      cnt_clamp;
  logic [BUSY_W-1:0]     arr_ext;
  logic [BUSY_W-1:0]     cur_busy;
  logic                  cur_free;
  logic [BUSY_W-1:0]     base;
  logic [BUSY_W:0]       busy_sum;
  logic [WAIT_W-1:0]     wait_val;
  logic [TOTAL_W:0]      total_sum;
  logic [SERVER_W+IDX_W-1:0] srv_ext;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign arr_ext     = {{(BUSY_W-ARRIVAL_W){1'b0}}, arrival_q};

  always_comb begin
    if (active_q == '0) begin
      cnt_clamp = CNT_W'(1);
    end else if (int'(active_q) > int'(NUM_SERVERS)) begin
      cnt_clamp = CNT_W'(NUM_SERVERS);
    end else begin
      cnt_clamp = CNT_W'(active_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d  = ST_SCAN;
          rd_idx_d = '0;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_idx_q == last_q) begin
          state_d = ST_LAST;
        end else begin
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
      end
      ST_LAST: state_d = ST_UPD;
      ST_UPD: begin
        if (out_free) begin
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // compare stage
  assign cur_busy = rd_vld_q ? rd_data_q : '0;
  assign cur_free = arr_ext >= cur_busy;

  // write-back values
  assign wr_idx   = found_q ? first_idx_q : best_idx_q;
  assign base     = found_q ? arr_ext : best_q;
  assign busy_sum = {1'b0, base} + {{(BUSY_W+1-DUR_W){1'b0}}, dur_q};
  assign wr_data  = busy_sum[BUSY_W] ? '1 : busy_sum[BUSY_W-1:0];
  assign wait_val = found_q ? '0 : WAIT_W'(best_q - arr_ext);
  assign total_sum = {1'b0, total_q} + {{(TOTAL_W+1-WAIT_W){1'b0}}, wait_val};
  assign srv_ext  = {{SERVER_W{1'b0}}, wr_idx};

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= busy_mem[rd_idx_q];
      rd_vld_q  <= ent_vld_q[rd_idx_q];
    end
    if (mem_we) begin
      busy_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      arrival_q <= req_i.arrival_time;
      dur_q     <= req_i.service_duration;
      last_q    <= IDX_W'(cnt_clamp - CNT_W'(1));
    end
    if (pend_vld_q) begin
      if (!found_q && cur_free) begin
        first_idx_q <= pend_idx_q;
      end
      if (pend_idx_q == '0 || cur_busy <= best_q) begin
        best_q     <= cur_busy;
        best_idx_q <= pend_idx_q;
      end
    end
    pend_idx_q <= rd_idx_q;
    if (mem_we) begin
      out_srv_q  <= srv_ext[SERVER_W-1:0];
      out_wait_q <= wait_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
      pend_vld_q <= 1'b0;
      found_q    <= 1'b0;
      ent_vld_q  <= '0;
      total_q    <= '0;
      long_q     <= '0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      pend_vld_q <= rd_en;
      if (req_acc) begin
        found_q <= 1'b0;
      end else if (pend_vld_q && cur_free) begin
        found_q <= 1'b1;
      end
      if (mem_we) begin
        ent_vld_q[wr_idx] <= 1'b1;
        total_q   <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        if (wait_val > {{(WAIT_W-THRESH_W){1'b0}}, thresh_q} && long_q != '1) begin
          long_q <= long_q + COUNT_W'(1);
        end
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + COUNT_W'(1);
        end
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.assigned_server = out_srv_q;
  assign rsp_o.wait_time       = out_wait_q;
  assign rsp_o.total_wait      = total_q;
  assign rsp_o.long_wait_count = long_q;
  assign rsp_o.requests_seen   = cnt_q;

  // write-back only targets an active server
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> wr_idx <= last_q)
    else $error("write-back index beyond active servers");

  // a free server means a zero wait on the result
  a_free_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && found_q) |=> out_wait_q == '0)
    else $error("nonzero wait with a free server");

  // request count advances by one per result, saturating
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (cnt_q == $past(cnt_q) + COUNT_W'(1)) ||
               ($past(cnt_q) == '1 && cnt_q == '1))
    else $error("request count step wrong");

  // wait total never goes down
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 total_q >= $past(total_q))
    else $error("wait total decreased");

  // scan reads stay inside the active range
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> rd_idx_q <= last_q)
    else $error("scan read beyond active servers");

endmodule

FILE: tb/tb_earliest_free_server_dispatcher_unit.sv
// self-checking testbench of the earliest-free server dispatcher: directed, random and
// backlog traffic over the request channel, apb register writes and reads between phases
// depends on efsd_pkg, efsd_if and earliest_free_server_dispatcher_unit
`timescale 1ns / 100ps

module tb_earliest_free_server_dispatcher_unit;
  import efsd_pkg::*;

  localparam int unsigned NSRV           = NUM_SERVERS_DEF;
  localparam int unsigned DRAIN_CYCLES   = NSRV + 16;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned BACKLOG_ITEMS  = 24;
  localparam logic [BUSY_W-1:0]  BUSY_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [SERVER_W-1:0] server;
    logic [WAIT_W-1:0]   wait_ticks;
    logic [TOTAL_W-1:0]  wait_total;
    logic [COUNT_W-1:0]  long_count;
    logic [COUNT_W-1:0]  req_count;
  } dispatch_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  efsd_req_if req_if ();
  efsd_rsp_if rsp_if ();

  earliest_free_server_dispatcher_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // dispatcher state as predicted by the testbench
  logic [ACTIVE_W-1:0] active_cfg = ACTIVE_RST;
  logic [THRESH_W-1:0] thresh_cfg = THRESH_RST;
  logic [BUSY_W-1:0]   busy_until [NSRV];
  logic [TOTAL_W-1:0]  wait_total = '0;
  logic [COUNT_W-1:0]  long_waits = '0;
  logic [COUNT_W-1:0]  req_total  = '0;

  dispatch_t   pending_q[$];
  int unsigned sent_count   = 0;
  int unsigned results_done = 0;
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  bit          src_idle_en  = 1'b0;
  bit          rx_idle_en   = 1'b0;
  bit          rx_hold_req  = 1'b0;

  function automatic dispatch_t dispatch_request(input logic [ARRIVAL_W-1:0] arr,
                                                 input logic [DUR_W-1:0] dur);
    dispatch_t          r;
    int unsigned        n;
    int unsigned        pick;
    bit                 found;
    logic [BUSY_W-1:0]  best;
    logic [BUSY_W-1:0]  arr_ext;
    logic [WAIT_W-1:0]  wt;
    logic [BUSY_W:0]    busy_sum;
    logic [TOTAL_W:0]   tot_sum;
    n = (active_cfg == '0) ? 1 : ((32'(active_cfg) > NSRV) ? NSRV : 32'(active_cfg));
    arr_ext = {{(BUSY_W-ARRIVAL_W){1'b0}}, arr};
    found = 1'b0;
    pick = 0;
    wt = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && arr_ext >= busy_until[i]) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (found) begin
      busy_sum = {1'b0, arr_ext} + {{(BUSY_W+1-DUR_W){1'b0}}, dur};
    end else begin
      best = busy_until[0];
      for (int i = 0; i < n; i++) begin
        if (busy_until[i] <= best) begin
          best = busy_until[i];
          pick = i;
        end
      end
      wt = best - arr_ext;
      busy_sum = {1'b0, best} + {{(BUSY_W+1-DUR_W){1'b0}}, dur};
    end
    busy_until[pick] = busy_sum[BUSY_W] ? BUSY_MAX : busy_sum[BUSY_W-1:0];
    tot_sum = {1'b0, wait_total} + {{(TOTAL_W+1-WAIT_W){1'b0}}, wt};
    wait_total = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
    if (wt > {{(WAIT_W-THRESH_W){1'b0}}, thresh_cfg} && long_waits != COUNT_MAX)
      long_waits = long_waits + COUNT_W'(1);
    if (req_total != COUNT_MAX) req_total = req_total + COUNT_W'(1);
    r.server     = pick[SERVER_W-1:0];
    r.wait_ticks = wt;
    r.wait_total = wait_total;
    r.long_count = long_waits;
    r.req_count  = req_total;
    return r;
  endfunction

  function automatic void report_mismatch(input string field, input logic [63:0] exp_v,
                                          input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      errors++;
    end
  endfunction

  // result checking, prediction on each accepted request, watchdog count
  always @(posedge clk_i) begin : result_check
    dispatch_t exp_r;
    bit        moved;
    moved = 1'b0;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      moved = 1'b1;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual server %0d",
                 $time, rsp_if.assigned_server);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        report_mismatch("assigned_server", 64'(exp_r.server), 64'(rsp_if.assigned_server));
        report_mismatch("wait_time", 64'(exp_r.wait_ticks), 64'(rsp_if.wait_time));
        report_mismatch("total_wait", 64'(exp_r.wait_total), 64'(rsp_if.total_wait));
        report_mismatch("long_wait_count", 64'(exp_r.long_count),
                        64'(rsp_if.long_wait_count));
        report_mismatch("requests_seen", 64'(exp_r.req_count), 64'(rsp_if.requests_seen));
        results_done++;
      end
    end
    if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      moved = 1'b1;
      pending_q.push_back(dispatch_request(req_if.arrival_time, req_if.service_duration));
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // result sink with random stalls and a long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        hold_left = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_request(input logic [ARRIVAL_W-1:0] arr, input logic [DUR_W-1:0] dur);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.arrival_time     <= arr;
    req_if.service_duration <= dur;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_done != sent_count) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic idx, input bit wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    rdata = prdata;
    if (wr) begin
      case (idx)
        REG_ACTIVE: active_cfg = wdata[ACTIVE_W-1:0];
        REG_THRESH: thresh_cfg = wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [APB_DATA_W-1:0] wdata);
    logic [APB_DATA_W-1:0] unused;
    reg_access(idx, 1'b1, wdata, unused);
  endtask

  task automatic reg_expect(input logic idx, input logic [APB_DATA_W-1:0] exp_v);
    logic [APB_DATA_W-1:0] got;
    reg_access(idx, 1'b0, '0, got);
    if (got !== exp_v) begin
      $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
               $time, idx, exp_v, got);
      errors++;
    end
  endtask

  task automatic test_reset_defaults();
    reg_expect(REG_ACTIVE, APB_DATA_W'(ACTIVE_RST));
    reg_expect(REG_THRESH, APB_DATA_W'(THRESH_RST));
    send_request('0, '0);
    send_request('0, '1);
    send_request(24'd5, 16'd3);
    send_request('1, '1);
    wait_idle();
  endtask

  task automatic test_register_access();
    logic [APB_DATA_W-1:0] v;
    v = $urandom();
    reg_write(REG_ACTIVE, v);
    reg_expect(REG_ACTIVE, APB_DATA_W'(v[ACTIVE_W-1:0]));
    v = ~v;
    reg_write(REG_THRESH, v);
    reg_expect(REG_THRESH, APB_DATA_W'(v[THRESH_W-1:0]));
    v = $urandom();
    reg_write(REG_ACTIVE, ~v);
    reg_expect(REG_ACTIVE, APB_DATA_W'(active_cfg));
    reg_write(REG_THRESH, v);
    reg_expect(REG_THRESH, APB_DATA_W'(thresh_cfg));
  endtask

  task automatic test_directed_cases();
    // server 0 is now busy past the largest arrival time
    reg_write(REG_ACTIVE, 32'd4);
    reg_write(REG_THRESH, 32'd0);
    repeat (3) send_request('1, '1);
    // all four tied, highest index wins
    send_request('1, 16'd1);
    send_request('1, 16'd0);
    wait_idle();
    // wait equal to the threshold is not a long wait
    reg_write(REG_THRESH, 32'hFFFF);
    send_request('1, 16'd0);
    wait_idle();
    reg_write(REG_THRESH, 32'hFFFE);
    send_request('1, 16'd0);
    wait_idle();
    // zero active servers behaves as one
    reg_write(REG_ACTIVE, 32'd0);
    send_request('1, 16'd5);
    send_request(24'd0, 16'd7);
    wait_idle();
    // more active servers than exist
    reg_write(REG_ACTIVE, 32'd31);
    send_request(24'd0, 16'd100);
    send_request(24'd0, 16'd100);
    wait_idle();
    reg_write(REG_ACTIVE, 32'd17);
    send_request(24'd0, 16'd100);
    send_request(24'd50, 16'd0);
    wait_idle();
    reg_write(REG_ACTIVE, 32'd16);
    send_request(24'd200, 16'd1);
    send_request(24'd100, '1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [ACTIVE_W-1:0]  act;
    logic [THRESH_W-1:0]  thr;
    logic [ARRIVAL_W-1:0] now;
    int unsigned          n;
    int unsigned          dur_max;
    int unsigned          step_max;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin act = 5'd16; thr = 16'd0; end
        1: begin act = 5'd1; thr = 16'hFFFF; end
        2: begin
          act = ACTIVE_W'($urandom_range(2, 15));
          thr = THRESH_W'($urandom_range(0, 200));
        end
        3: begin
          act = 5'd0;
          thr = THRESH_W'($urandom_range(0, 65535));
        end
        4: begin
          act = ACTIVE_W'($urandom_range(17, 31));
          thr = THRESH_W'($urandom_range(0, 2000));
        end
        default: begin
          act = ACTIVE_W'($urandom_range(1, 16));
          thr = THRESH_W'($urandom_range(0, 500));
        end
      endcase
      wait_idle();
      reg_write(REG_ACTIVE, ($urandom() & ~32'h1F) | APB_DATA_W'(act));
      reg_write(REG_THRESH, ($urandom() & ~32'hFFFF) | APB_DATA_W'(thr));
      src_idle_en = (ph != 5);
      rx_idle_en  = (ph != 5);
      n = (act == '0) ? 1 : ((32'(act) > NSRV) ? NSRV : 32'(act));
      case ($urandom_range(0, 3))
        0: dur_max = 15;
        1: dur_max = 255;
        2: dur_max = 4095;
        default: dur_max = 65535;
      endcase
      step_max = $urandom_range(1, dur_max / n + 2);
      now = ARRIVAL_W'($urandom_range(0, 24'hFFFFFF));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 60) rx_hold_req = 1'b1;
        if (ph == 1 && k == 100) wait_idle();
        if ($urandom_range(0, 9) == 0) begin
          send_request(ARRIVAL_W'($urandom_range(0, 24'hFFFFFF)),
                       DUR_W'($urandom_range(0, 16'hFFFF)));
        end else begin
          send_request(now, DUR_W'($urandom_range(0, dur_max)));
          now = now + ARRIVAL_W'($urandom_range(0, step_max));
        end
      end
    end
  endtask

  task automatic test_backlog();
    wait_idle();
    reg_write(REG_ACTIVE, 32'd1);
    reg_write(REG_THRESH, 32'hFFFF);
    src_idle_en = 1'b0;
    rx_idle_en  = 1'b0;
    // one server falls far behind, waits climb well past the threshold
    repeat (BACKLOG_ITEMS) send_request('0, '1);
    wait_idle();
  endtask

  initial begin : stimulus
    for (int i = 0; i < NSRV; i++) busy_until[i] = '0;
    rst_ni                  <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    req_if.valid            <= 1'b0;
    req_if.arrival_time     <= '0;
    req_if.service_duration <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_access();
    test_directed_cases();
    test_random_traffic();
    test_backlog();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/efsd_pkg.sv
rtl/efsd_if.sv
rtl/earliest_free_server_dispatcher_unit.sv
tb/tb_earliest_free_server_dispatcher_unit.sv
